[hw/rtl/perceptron_train_classify_assert.svh]
// ----------------------------------------------------------------------------
// perceptron trainer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_TRAIN_CLASSIFY_ASSERT_SVH
`define PERCEPTRON_TRAIN_CLASSIFY_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("perceptron trainer assertion failed");

// next-cycle implication
`define PTC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("perceptron trainer assertion failed");

`endif

[hw/rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// types and constants shared by the perceptron trainer modules
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  // vector length and derived widths
  localparam int N_FEATURES = 16;
  localparam int CNT_W      = $clog2(N_FEATURES + 1);
  localparam int AW         = (N_FEATURES > 1) ? $clog2(N_FEATURES) : 1;

  // fixed constants
  localparam logic [63:0] BIAS_Q16    = 64'h0000_0000_0001_0000;
  localparam logic [15:0] LR_RESET    = 16'd6554;
  localparam logic [15:0] SAT16       = 16'hFFFF;
  localparam logic [31:0] WT_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] WT_MIN      = 32'h8000_0000;

  // configuration register map (word index)
  localparam logic REG_LEARN_RATE = 1'b0;

  // input beat
  typedef struct packed {
    logic               mode;
    logic signed [15:0] feature;
    logic               target;
    logic               last_feature;
    logic               end_of_epoch;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic        predicted_class;
    logic        mistake;
    logic [15:0] epoch_mistakes;
    logic        converged;
    logic [15:0] epoch_count;
  } out_item_t;

  // shared arithmetic unit request and response
  typedef struct packed {
    logic               mul_en;
    logic signed [15:0] mul_a;
    logic signed [31:0] mul_b;
    logic [63:0]        acc;
    logic signed [31:0] wt;
  } alu_req_t;

  typedef struct packed {
    logic [63:0]        acc_sum;
    logic signed [31:0] wt_sat;
  } alu_rsp_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MAC  = 6'b000010,
    ST_FIN  = 6'b000100,
    ST_UMUL = 6'b001000,
    ST_UADD = 6'b010000,
    ST_OUT  = 6'b100000
  } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/ptc_alu.sv]
// ----------------------------------------------------------------------------
// ptc_alu
// shared 16x32 multiplier with registered product, 64-bit accumulate adder
// and saturating 32-bit weight adder
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_alu (
  input  wire logic              clk,
  input  wire ptc_pkg::alu_req_t req,
  output ptc_pkg::alu_rsp_t      rsp
);

  logic signed [47:0] prod_r;
  logic [48:0]        wsum;
  logic               wsum_ok;

  // multiplier stage, product held for the add cycle
  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod_r <= req.mul_a * req.mul_b;
    end
  end

  // weight update with clamp to the signed 32-bit range
  assign wsum    = {{17{req.wt[31]}}, req.wt} + {prod_r[47], prod_r};
  assign wsum_ok = (&wsum[48:31]) || !(|wsum[48:31]);

  // accumulate for the weighted sum, clamped weight sum
  always_comb begin
    rsp.acc_sum = req.acc + {{16{prod_r[47]}}, prod_r};
    if (wsum_ok) begin
      rsp.wt_sat = wsum[31:0];
    end else if (wsum[48]) begin
      rsp.wt_sat = ptc_pkg::WT_MIN;
    end else begin
      rsp.wt_sat = ptc_pkg::WT_MAX;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ptc_seq.sv]
// ----------------------------------------------------------------------------
// ptc_seq
// sequencer: buffers features, drives the shared unit for the dot product
// and the weight walk, keeps epoch counters and the result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "perceptron_train_classify_assert.svh"

module ptc_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ptc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ptc_pkg::out_item_t      out_data,
  input  wire logic [15:0]        learn_rate,
  output ptc_pkg::alu_req_t       alu_req,
  input  wire ptc_pkg::alu_rsp_t  alu_rsp
);

  ptc_pkg::seq_state_t             state_r;
  logic [ptc_pkg::CNT_W-1:0]       idx_r;
  logic [ptc_pkg::CNT_W-1:0]       walk_r;
  logic [ptc_pkg::CNT_W-1:0]       walk_nxt;
  logic [63:0]                     acc_r;
  logic signed [31:0]              wt_r [ptc_pkg::N_FEATURES];
  logic signed [15:0]              fb_r [ptc_pkg::N_FEATURES];
  ptc_pkg::in_item_t               item_r;
  logic signed [17:0]              step_r;
  logic signed [17:0]              step_nxt;
  logic [17:0]                     lr2;
  logic                            cls_r;
  logic                            wrong_r;
  logic [15:0]                     mc_r;
  logic [15:0]                     ep_r;
  logic [15:0]                     ep_nxt;
  logic                            out_valid_r;
  ptc_pkg::out_item_t              out_data_r;
  logic                            in_acc;
  logic                            has_room;
  logic [ptc_pkg::AW-1:0]          addr;
  logic [ptc_pkg::AW-1:0]          waddr;
  logic [63:0]                     sum;
  logic                            cls;
  logic                            wrong;
  logic                            out_free;
  logic                            epoch_end;

  // handshake and index decode
  assign in_stall  = (state_r != ptc_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign has_room  = (idx_r < ptc_pkg::CNT_W'(ptc_pkg::N_FEATURES));
  assign addr      = idx_r[ptc_pkg::AW-1:0];
  assign waddr     = walk_r[ptc_pkg::AW-1:0];
  assign walk_nxt  = walk_r + 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // class decision on the closed vector
  assign sum   = acc_r + ptc_pkg::BIAS_Q16;
  assign cls   = !sum[63];
  assign wrong = item_r.mode && (cls != item_r.target);

  // update step is +/- 2 * learn_rate
  assign lr2      = {1'b0, learn_rate, 1'b0};
  assign step_nxt = item_r.target ? $signed(lr2) : -$signed(lr2);

  // epoch bookkeeping at result time
  assign epoch_end = item_r.mode && item_r.end_of_epoch;
  assign ep_nxt    = (ep_r != ptc_pkg::SAT16) ? ep_r + 16'd1 : ep_r;

  // shared unit operand select
  always_comb begin
    alu_req.mul_en = (in_acc && has_room) || (state_r == ptc_pkg::ST_UMUL);
    alu_req.acc    = acc_r;
    alu_req.wt     = wt_r[waddr];
    if (state_r == ptc_pkg::ST_IDLE) begin
      alu_req.mul_a = in_data.feature;
      alu_req.mul_b = wt_r[addr];
    end else begin
      alu_req.mul_a = fb_r[waddr];
      alu_req.mul_b = {{14{step_r[17]}}, step_r};
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptc_pkg::ST_IDLE;
      idx_r       <= '0;
      walk_r      <= '0;
      acc_r       <= '0;
      mc_r        <= '0;
      ep_r        <= '0;
      for (int i = 0; i < ptc_pkg::N_FEATURES; i++) begin
        wt_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        ptc_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (has_room) begin
              state_r <= ptc_pkg::ST_MAC;
            end else if (in_data.last_feature) begin
              state_r <= ptc_pkg::ST_FIN;
            end
          end
        end
        ptc_pkg::ST_MAC: begin
          acc_r   <= alu_rsp.acc_sum;
          idx_r   <= idx_r + 1'b1;
          state_r <= item_r.last_feature ? ptc_pkg::ST_FIN : ptc_pkg::ST_IDLE;
        end
        ptc_pkg::ST_FIN: begin
          walk_r <= '0;
          if (wrong) begin
            if (mc_r != ptc_pkg::SAT16) begin
              mc_r <= mc_r + 16'd1;
            end
            state_r <= (idx_r != '0) ? ptc_pkg::ST_UMUL : ptc_pkg::ST_OUT;
          end else begin
            state_r <= ptc_pkg::ST_OUT;
          end
        end
        ptc_pkg::ST_UMUL: begin
          state_r <= ptc_pkg::ST_UADD;
        end
        ptc_pkg::ST_UADD: begin
          wt_r[waddr] <= alu_rsp.wt_sat;
          walk_r      <= walk_nxt;
          state_r     <= (walk_nxt == idx_r) ? ptc_pkg::ST_OUT : ptc_pkg::ST_UMUL;
        end
        ptc_pkg::ST_OUT: begin
          if (out_free) begin
            acc_r       <= '0;
            idx_r       <= '0;
            state_r     <= ptc_pkg::ST_IDLE;
            if (epoch_end) begin
              mc_r <= '0;
              ep_r <= ep_nxt;
            end
          end
        end
        default: begin
          state_r <= ptc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // result valid: set on the result beat, cleared once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ptc_pkg::ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
      if (has_room) begin
        fb_r[addr] <= in_data.feature;
      end
    end
    if (state_r == ptc_pkg::ST_FIN) begin
      cls_r   <= cls;
      wrong_r <= wrong;
      step_r  <= step_nxt;
    end
    if ((state_r == ptc_pkg::ST_OUT) && out_free) begin
      out_data_r.predicted_class <= cls_r;
      out_data_r.mistake         <= wrong_r;
      out_data_r.epoch_mistakes  <= mc_r;
      out_data_r.converged       <= epoch_end && (mc_r == '0);
      out_data_r.epoch_count     <= epoch_end ? ep_nxt : ep_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PTC_ASSERT_NXT(a_buffered_beat_macs, in_acc && has_room, state_r == ptc_pkg::ST_MAC)
  `PTC_ASSERT_IMP(a_walk_in_range, state_r == ptc_pkg::ST_UMUL, walk_r < idx_r)
  `PTC_ASSERT_IMP(a_result_from_out, $rose(out_valid_r), $past(state_r == ptc_pkg::ST_OUT))
  `PTC_ASSERT_IMP(a_conv_no_mistakes, out_valid_r && out_data_r.converged,
                  out_data_r.epoch_mistakes == 16'd0 && !out_data_r.mistake)

endmodule

`default_nettype wire

[hw/rtl/perceptron_train_classify.sv]
// a feature beat is multiplied, then accumulated into the 64-bit sum
// a last_feature beat passes through ST_FIN and ST_OUT to its result with no weight change
// a misclassified training vector adds a weight walk, ST_UMUL then ST_UADD per buffered element
// in_stall holds off the next element until the current one is done, set by the single shared multiplier and adder
// reset: synchronous active-low rst_n clears weights, counters and sum; learn_rate = 6554
// ----------------------------------------------------------------------------
// perceptron_train_classify
// single-layer perceptron classifier and trainer with an apb register port
// ----------------------------------------------------------------------------
`default_nettype none

module perceptron_train_classify (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ptc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ptc_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0]        learn_rate_r;
  logic               cfg_wr;
  ptc_pkg::alu_req_t  alu_req;
  ptc_pkg::alu_rsp_t  alu_rsp;

  // register write on the access beat
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= ptc_pkg::LR_RESET;
    end else if (cfg_wr && (paddr[2] == ptc_pkg::REG_LEARN_RATE)) begin
      learn_rate_r <= pwdata[15:0];
    end
  end

  // register read
  always_comb begin
    unique case (paddr[2])
      ptc_pkg::REG_LEARN_RATE: prdata = {16'd0, learn_rate_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // sequencer
  ptc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .learn_rate (learn_rate_r),
    .alu_req    (alu_req),
    .alu_rsp    (alu_rsp)
  );

  // shared arithmetic unit
  ptc_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

`default_nettype wire
